[src/tct_pkg.sv]
// Package for the TCP connection tracker.
// Holds the table geometry, flag masks, status and connection state codes, and the
// sequencer state type. It depends on nothing else.
package tct_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	localparam logic [15:0] MIN_SEGMENT = 16'd20;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [3:0] ST_CLOSED       = 4'd0;
	localparam logic [3:0] ST_LISTEN       = 4'd1;
	localparam logic [3:0] ST_SYN_RECEIVED = 4'd3;
	localparam logic [3:0] ST_ESTABLISHED  = 4'd4;
	localparam logic [3:0] ST_CLOSE_WAIT   = 4'd7;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_LOOKUP,
		SEQ_UPDATE
	} seq_state_t;

	typedef struct packed {
		logic [3:0]  state;
		logic [31:0] ack;
	} conn_entry_t;

endpackage

[src/tcp_connection_tracker.sv]
// TCP connection tracker, top level.
// Uses tct_pkg for constants and types; holds the key registers and the
// per-connection state memory.

// A segment is taken when start is high and busy is low. In the lookup state the
// four-tuple is compared with every key register at once and the connection memory
// is read. In the update state the rules are applied and, if the status is OK, the
// entry is written back. The result is registered from the update state and shown
// for exactly one cycle with done high, and it cannot be held off. busy falls
// as the result appears, so a new segment may be accepted at the edge that takes the
// result. After reset the table is empty and needs no clearing pass.
module tcp_connection_tracker
	import tct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] local_address,
	input  logic [15:0] dest_port,
	input  logic [31:0] remote_address,
	input  logic [15:0] src_port,
	input  logic [31:0] seq_number,
	input  logic [7:0]  tcp_flags,
	input  logic [15:0] segment_length,
	input  logic [3:0]  data_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  entry_index,
	output logic        entry_created,
	output logic [3:0]  conn_state,
	output logic [31:0] ack_number,
	output logic        deliver_payload,
	output logic [15:0] payload_length
);

	seq_state_t seq_q, seq_d;

	logic [31:0] laddr_q, raddr_q, seqn_q;
	logic [15:0] lport_q, rport_q, seglen_q;
	logic [7:0]  flags_q;
	logic [3:0]  doff_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0] key_laddr_q [TABLE_DEPTH];
	logic [15:0] key_lport_q [TABLE_DEPTH];
	logic [31:0] key_raddr_q [TABLE_DEPTH];
	logic [15:0] key_rport_q [TABLE_DEPTH];
	logic [CNT_W-1:0] used_q;

	conn_entry_t conn_mem [TABLE_DEPTH];
	conn_entry_t mem_rd_q;

	logic [TABLE_DEPTH-1:0] hit_vec;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   full;
	logic                   short_seg;
	logic                   alloc;

	logic [IDX_W-1:0] idx_q;
	logic [1:0]       err_q;
	logic             created_q;

	logic        accept;
	conn_entry_t cur;
	logic [3:0]  st_syn, st_ack, st_fin;
	logic [31:0] ack_syn, ack_fin;
	logic [5:0]  hdr_len;
	logic        deliver;
	logic [15:0] plen;

	function automatic logic tcp_flags_has(input logic [7:0] flags, input logic [7:0] mask);
		tcp_flags_has = (flags & mask) != 8'd0;
	endfunction

	assign accept    = start && (seq_q == SEQ_IDLE);
	assign short_seg = seglen_q < MIN_SEGMENT;
	assign full      = used_q == CNT_W'(TABLE_DEPTH);

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && key_laddr_q[i] == laddr_q && key_lport_q[i] == lport_q
				&& key_raddr_q[i] == raddr_q && key_rport_q[i] == rport_q;
		end
	end

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign alloc = (seq_q == SEQ_LOOKUP) && !short_seg && !hit && !full;

	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SEQ_IDLE: begin
				if (start) seq_d = SEQ_LOOKUP;
			end
			SEQ_LOOKUP: seq_d = SEQ_UPDATE;
			SEQ_UPDATE: seq_d = SEQ_IDLE;
			default:    seq_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		busy = seq_q != SEQ_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			laddr_q  <= local_address;
			lport_q  <= dest_port;
			raddr_q  <= remote_address;
			rport_q  <= src_port;
			seqn_q   <= seq_number;
			flags_q  <= tcp_flags;
			seglen_q <= segment_length;
			doff_q   <= data_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (alloc) begin
			valid_q[used_q[IDX_W-1:0]] <= 1'b1;
			used_q <= used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (alloc) begin
			key_laddr_q[used_q[IDX_W-1:0]] <= laddr_q;
			key_lport_q[used_q[IDX_W-1:0]] <= lport_q;
			key_raddr_q[used_q[IDX_W-1:0]] <= raddr_q;
			key_rport_q[used_q[IDX_W-1:0]] <= rport_q;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_LOOKUP) begin
			idx_q     <= hit ? hit_idx : used_q[IDX_W-1:0];
			created_q <= !hit;
			if (short_seg) begin
				err_q <= STATUS_SHORT;
			end else if (!hit && full) begin
				err_q <= STATUS_FULL;
			end else begin
				err_q <= STATUS_OK;
			end
		end
	end

	// Synchronous read of the connection memory; no two transactions overlap, so the
	// write-back of one always lands before the read of the next.
	always_ff @(posedge clk) begin
		if (seq_q == SEQ_LOOKUP) begin
			mem_rd_q <= conn_mem[hit_idx];
		end
	end

	always_comb begin
		if (created_q) begin
			cur.state = ST_CLOSED;
			cur.ack   = '0;
		end else begin
			cur = mem_rd_q;
		end

		st_syn  = cur.state;
		ack_syn = cur.ack;
		if ((tcp_flags_has(flags_q, FLAG_SYN))
			&& (cur.state == ST_CLOSED || cur.state == ST_LISTEN)) begin
			st_syn  = ST_SYN_RECEIVED;
			ack_syn = seqn_q + 32'd1;
		end

		st_ack = st_syn;
		if (tcp_flags_has(flags_q, FLAG_ACK) && st_syn == ST_SYN_RECEIVED) begin
			st_ack = ST_ESTABLISHED;
		end

		hdr_len = {doff_q, 2'b00};
		deliver = (st_ack == ST_ESTABLISHED) && (seglen_q > {10'd0, hdr_len});
		plen    = deliver ? (seglen_q - {10'd0, hdr_len}) : '0;

		st_fin  = st_ack;
		ack_fin = ack_syn;
		if (tcp_flags_has(flags_q, FLAG_FIN) && st_ack == ST_ESTABLISHED) begin
			st_fin  = ST_CLOSE_WAIT;
			ack_fin = seqn_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_UPDATE && err_q == STATUS_OK) begin
			conn_mem[idx_q] <= '{state: st_fin, ack: ack_fin};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= seq_q == SEQ_UPDATE;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_UPDATE) begin
			status <= err_q;
			if (err_q == STATUS_OK) begin
				entry_index     <= 4'(idx_q);
				entry_created   <= created_q;
				conn_state      <= st_fin;
				ack_number      <= ack_fin;
				deliver_payload <= deliver;
				payload_length  <= plen;
			end else begin
				entry_index     <= '0;
				entry_created   <= 1'b0;
				conn_state      <= '0;
				ack_number      <= '0;
				deliver_payload <= 1'b0;
				payload_length  <= '0;
			end
		end
	end

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("More than one table entry matches the same four-tuple.");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("Allocation count exceeds the table depth.");

	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##2 done)
		else $error("Result did not appear three cycles after acceptance.");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (!entry_created && !deliver_payload))
		else $error("Rejected transaction reports an allocation or payload.");

endmodule
